### src/fba_pkg.sv
// Shared types and constants of the frame bitmap allocator.
package fba_pkg;

  localparam int FBA_MAX_FRAMES  = 65536;
  localparam int FBA_FRAME_SHIFT = 12;
  localparam int FBA_WORD_BITS   = 64;

  localparam int ADDR_W   = 48;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 17;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 3'd0,
    KIND_FREE    = 3'd1,
    KIND_MARK    = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_RESERVE = 3'd4
  } fba_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } fba_status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_MOD,
    ST_SWEEP,
    ST_RESP
  } fba_state_e;

endpackage

### src/fba_bitmap_ram.sv
// Single-port-write, registered-read word memory for the frame bitmap.
module fba_bitmap_ram #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 64,
  parameter int IW        = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [IW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/frame_bitmap_allocator_unit.sv
// Top level of the first-fit bitmap frame allocator.
//
// Usage: items enter on in_valid_i / in_stall_o with kind, byte address and length.
// Every item yields exactly one result item on out_valid_o / out_stall_i carrying a
// status and, for a successful alloc, the byte address of the frame taken.
// The frame total is written through cfg_valid_i / cfg_ready_o / cfg_data_i while idle;
// values above MAX_FRAMES act as MAX_FRAMES.
//
// The bitmap lives in one memory of MAX_FRAMES/WORD_BITS words with a registered read.
// Each word visited passes a read state, then a modify-and-write-back state:
//   alloc            : words are scanned up to the first free bit
//   free/range kinds : only the words of the range are touched, none when it is empty
//   mark_all_used    : every word is written, one word written per cycle
// One item is worked on at a time; the next is taken once the result sits in the
// output register, so a stalled receiver only stops the block at the following result.
//
// Reset: the frame total returns to MAX_FRAMES and a fill pass writes all ones into
// every word (1024 words by default); in_stall_o stays high
// meanwhile. Configuration writes are taken at any time.
module frame_bitmap_allocator_unit
  import fba_pkg::*;
#(
  parameter int MAX_FRAMES  = FBA_MAX_FRAMES,
  parameter int FRAME_SHIFT = FBA_FRAME_SHIFT,
  parameter int WORD_BITS   = FBA_WORD_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   in_kind_i,
  input  logic [ADDR_W-1:0]   in_addr_i,
  input  logic [ADDR_W-1:0]   in_length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [ADDR_W-1:0]   out_frame_addr_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TOTAL_W-1:0]  cfg_data_i
);

  localparam int DEPTH  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int FNW    = ADDR_W - FRAME_SHIFT + 2;
  localparam int MAXW   = $clog2(MAX_FRAMES + 1);
  localparam int TOT_W  = (MAXW > TOTAL_W) ? MAXW : TOTAL_W;
  localparam logic [TOT_W-1:0]  MAX_TOT    = TOT_W'(MAX_FRAMES);
  localparam logic [IW-1:0]     LAST_WORD  = IW'(DEPTH - 1);
  localparam logic [ADDR_W:0]   FRAME_MASK = (ADDR_W+1)'((64'd1 << FRAME_SHIFT) - 64'd1);

  // State and registers
  fba_state_e            state_q, state_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [FNW-1:0]        lo_q, lo_d;
  logic [FNW-1:0]        aux_q, aux_d;
  logic [IW-1:0]         w_q, w_d;
  logic [IW-1:0]         first_w_q, first_w_d;
  logic [IW-1:0]         last_w_q, last_w_d;
  logic [BW-1:0]         first_b_q, first_b_d;
  logic [BW-1:0]         last_b_q, last_b_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [ADDR_W-1:0]     out_addr_q, out_addr_d;
  logic [TOT_W-1:0]      total_q;

  // Memory port
  logic                  ram_we, ram_re;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  // Datapath helpers
  logic [TOT_W-1:0]      tot;
  logic [FNW-1:0]        tot_f;
  logic [FNW-1:0]        last_f, hi_f, hm1_f;
  logic [ADDR_W:0]       sum_a, sum_b;
  logic [WORD_BITS-1:0]  mask, cand, pick;
  logic [BW-1:0]         pos;
  logic                  found, in_acc, out_free;
  logic [IW+BW-1:0]      frame_no;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Clamp the configured total to the store size
  assign tot   = (total_q > MAX_TOT) ? MAX_TOT : total_q;
  assign tot_f = {{(FNW-TOT_W){1'b0}}, tot};

  // Per-word bit range: bits of the first and last word are trimmed
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = ((w_q != first_w_q) || (BW'(i) >= first_b_q)) &&
                ((w_q != last_w_q) || (BW'(i) <= last_b_q));
    end
  end

  assign cand  = ~ram_rdata & mask;
  assign found = |cand;

  // Lowest free bit of the word
  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = BW'(i);
      end
    end
  end

  assign pick     = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos;
  assign frame_no = {w_q, pos};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (w_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind_i)
            KIND_ALLOC, KIND_FREE, KIND_RELEASE, KIND_RESERVE: state_d = ST_CALC;
            KIND_MARK: state_d = ST_SWEEP;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_CALC:  state_d = (hi_f > lo_q) ? ST_READ : ST_RESP;
      ST_READ:  state_d = ST_MOD;
      ST_MOD: begin
        if ((kind_q == KIND_ALLOC && found) || (w_q == last_w_q)) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_SWEEP: begin
        if (w_q == LAST_WORD) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign sum_a  = {1'b0, in_addr_i} + FRAME_MASK;
  assign sum_b  = {1'b0, in_addr_i} + {1'b0, in_length_i};
  assign last_f = (kind_q inside {KIND_FREE, KIND_RESERVE}) ? lo_q + aux_q : aux_q;
  assign hi_f   = (last_f < tot_f) ? last_f : tot_f;
  assign hm1_f  = hi_f - {{(FNW-1){1'b0}}, 1'b1};

  // Outputs and datapath
  always_comb begin
    kind_d       = kind_q;
    lo_d         = lo_q;
    aux_d        = aux_q;
    w_d          = w_q;
    first_w_d    = first_w_q;
    last_w_d     = last_w_q;
    first_b_d    = first_b_q;
    last_b_d     = last_b_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = '1;
    in_stall_o   = (state_q != ST_IDLE);

    case (state_q)
      ST_INIT: begin
        ram_we = 1'b1;
        w_d    = w_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          kind_d       = in_kind_i;
          res_status_d = STATUS_OK;
          res_addr_d   = '0;
          w_d          = '0;
          case (in_kind_i)
            KIND_ALLOC: begin
              lo_d  = '0;
              aux_d = tot_f;
            end
            KIND_FREE: begin
              lo_d  = FNW'(in_addr_i >> FRAME_SHIFT);
              aux_d = {{(FNW-1){1'b0}}, 1'b1};
            end
            KIND_RELEASE: begin
              lo_d  = FNW'(sum_a >> FRAME_SHIFT);
              aux_d = FNW'(sum_b >> FRAME_SHIFT);
            end
            KIND_RESERVE: begin
              lo_d  = FNW'(in_addr_i >> FRAME_SHIFT);
              aux_d = FNW'(({1'b0, in_length_i} + FRAME_MASK) >> FRAME_SHIFT);
            end
            default: begin
              lo_d = lo_q;
            end
          endcase
        end
      end
      ST_CALC: begin
        // Clip the range to the managed total and latch word bounds
        if (kind_q == KIND_ALLOC) begin
          res_status_d = STATUS_NO_FREE;
        end else if (last_f > lo_q && last_f > tot_f) begin
          res_status_d = STATUS_OUTSIDE;
        end
        first_w_d = lo_q[BW +: IW];
        first_b_d = lo_q[BW-1:0];
        last_w_d  = hm1_f[BW +: IW];
        last_b_d  = hm1_f[BW-1:0];
        w_d       = lo_q[BW +: IW];
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_MOD: begin
        if (kind_q == KIND_ALLOC) begin
          if (found) begin
            ram_we       = 1'b1;
            ram_wdata    = ram_rdata | pick;
            res_status_d = STATUS_OK;
            res_addr_d   = {{(ADDR_W-IW-BW){1'b0}}, frame_no} << FRAME_SHIFT;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = (kind_q == KIND_RESERVE) ? (ram_rdata | mask) : (ram_rdata & ~mask);
        end
        w_d = w_q + 1'b1;
      end
      ST_SWEEP: begin
        ram_we = 1'b1;
        w_d    = w_q + 1'b1;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      w_q         <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      total_q     <= MAX_TOT;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= TOT_W'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    aux_q        <= aux_d;
    first_w_q    <= first_w_d;
    last_w_q     <= last_w_d;
    first_b_q    <= first_b_d;
    last_b_q     <= last_b_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  fba_bitmap_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .IW        (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (w_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_frame_addr_o = out_addr_q;

  // Only a successful alloc carries an address
  a_addr_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != STATUS_OK) |-> out_frame_addr_o == '0)
    else $error("address on failed result");

  // An alloc write-back takes exactly one more frame
  a_alloc_one_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) && (kind_q == KIND_ALLOC) && ram_we |->
      $countones(ram_wdata) == $countones(ram_rdata) + 1)
    else $error("alloc changed more than one bit");

  // An accepted item always leaves idle
  a_leave_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted item dropped");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the frame bitmap allocator, driven by directed and random items.
module tb_top;
  import fba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kind codes above the defined set; the block must ignore them.
  localparam logic [KIND_W-1:0] KIND_UNDEF_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNDEF_LAST  = 3'd7;
  localparam int NUM_WORDS   = FBA_MAX_FRAMES / 64;
  localparam int PAGE_BYTES  = 1 << FBA_FRAME_SHIFT;
  localparam int STALL_LIMIT = 12000;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned ADDR_ALL = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   frame_addr;
  } alloc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   in_kind_i = '0;
  logic [ADDR_W-1:0]   in_addr_i = '0;
  logic [ADDR_W-1:0]   in_length_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] out_status_o;
  logic [ADDR_W-1:0]   out_frame_addr_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [TOTAL_W-1:0]  cfg_data_i = '0;

  // Predictor state: one bit per frame, one means used.
  bit [63:0]        frame_map [NUM_WORDS];
  longint unsigned  total_reg;
  alloc_result_t    pending_results[$];

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;    // run both sides flat out while set
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off

  frame_bitmap_allocator_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic longint unsigned managed_frames();
    return (total_reg > FBA_MAX_FRAMES) ? FBA_MAX_FRAMES : total_reg;
  endfunction

  function automatic void mark_every_frame();
    foreach (frame_map[w]) frame_map[w] = '1;
  endfunction

  // Apply to frames [first, last) below the total; return the status.
  function automatic logic [STATUS_W-1:0] put_frames(longint unsigned first,
                                                     longint unsigned last, bit used);
    longint unsigned tot;
    longint unsigned hi;
    tot = managed_frames();
    hi  = (last < tot) ? last : tot;
    if (last <= first) return STATUS_OK;
    for (longint unsigned f = first; f < hi; f++)
      frame_map[f >> 6][f[5:0]] = used;
    return (last > tot) ? STATUS_OUTSIDE : STATUS_OK;
  endfunction

  function automatic alloc_result_t predict_item(logic [KIND_W-1:0] kind,
                                                 longint unsigned addr,
                                                 longint unsigned len);
    alloc_result_t   res;
    longint unsigned tot;
    longint unsigned f;
    longint unsigned base;
    longint unsigned stop;
    bit              found;
    res   = '{status: STATUS_OK, frame_addr: '0};
    tot   = managed_frames();
    found = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        res.status = STATUS_NO_FREE;
        for (int w = 0; w < NUM_WORDS && !found && w * 64 < tot; w++) begin
          if (~frame_map[w] != 0) begin
            for (int b = 0; b < 64 && !found; b++) begin
              f = w * 64 + b;
              if (f < tot && !frame_map[w][b]) begin
                frame_map[w][b] = 1'b1;
                res.status      = STATUS_OK;
                res.frame_addr  = ADDR_W'((f << FBA_FRAME_SHIFT) & ADDR_ALL);
                found           = 1'b1;
              end
            end
          end
        end
      end
      KIND_FREE: begin
        f = addr >> FBA_FRAME_SHIFT;
        if (f < tot) frame_map[f >> 6][f[5:0]] = 1'b0;
        else res.status = STATUS_OUTSIDE;
      end
      KIND_MARK: mark_every_frame();
      KIND_RELEASE: begin
        base = (addr + PAGE_BYTES - 1) & ~longint'(PAGE_BYTES - 1);
        stop = (addr + len) & ~longint'(PAGE_BYTES - 1);
        if (stop > base)
          res.status = put_frames(base >> FBA_FRAME_SHIFT, stop >> FBA_FRAME_SHIFT, 1'b0);
      end
      KIND_RESERVE: begin
        f = addr >> FBA_FRAME_SHIFT;
        res.status = put_frames(f, f + ((len + PAGE_BYTES - 1) >> FBA_FRAME_SHIFT), 1'b1);
      end
      default: ;
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------
  task automatic send_item(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                           logic [ADDR_W-1:0] len);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_kind_i   <= kind;
    in_addr_i   <= addr;
    in_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_item(kind, addr, len));
  endtask

  // Wait until every result is back so the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic write_total(logic [TOTAL_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    total_reg = value;
  endtask

  // Receiver: draw a hold-off per result, or one long one on request.
  initial begin
    int w;
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 14);
      if (hold_req) begin
        w = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: status %0d addr %h", out_status_o, out_frame_addr_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.status !== out_status_o || exp_res.frame_addr !== out_frame_addr_o) begin
          error_count++;
          if (error_count <= 10)
            $display("result wrong: status exp %0d got %0d, addr exp %h got %h",
                     exp_res.status, out_status_o, exp_res.frame_addr, out_frame_addr_o);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("frame_bitmap_allocator_unit: mismatch");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------
  task automatic test_directed();
    send_item(KIND_ALLOC, '0, '0);                          // nothing free after reset
    send_item(KIND_RELEASE, '0, 48'h1000_0000);             // release all managed frames
    send_item(KIND_ALLOC, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_ALLOC, '0, '0);
    send_item(KIND_FREE, 48'h0000_0000_0FFF, '0);
    send_item(KIND_ALLOC, '0, '0);
    send_item(KIND_RESERVE, 48'h0000_0000_0001, 48'h0000_0000_2001); // rounds up to 3
    send_item(KIND_RELEASE, 48'h0000_0000_0001, 48'h0000_0000_2000); // unaligned ends
    send_item(KIND_RELEASE, 48'h0000_0000_5000, '0);        // empty region
    send_item(KIND_RELEASE, 48'h0000_0000_9FFF, 48'h0000_0000_0002); // empty after align
    send_item(KIND_RELEASE, '0, 48'hFFFF_FFFF_FFFF);        // runs past the total
    send_item(KIND_RESERVE, 48'h0000_0000_3000, '0);        // zero length
    send_item(KIND_RESERVE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_FREE, 48'hFFFF_FFFF_FFFF, '0);           // beyond the total
    send_item(KIND_FREE, 48'h0000_0FFF_F000, '0);           // last managed frame
    for (logic [KIND_W-1:0] k = KIND_UNDEF_FIRST; k <= KIND_UNDEF_LAST; k++) begin
      send_item(k, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      if (k == KIND_UNDEF_LAST) break;
    end
    send_item(KIND_MARK, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(KIND_ALLOC, '0, '0);
  endtask

  // Mostly well-formed traffic around the managed frames, some raw noise.
  task automatic random_items(int count);
    longint unsigned span;
    int              pick;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] l;
    span = managed_frames() + 16;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      a = ADDR_W'($urandom_range(0, int'(span) - 1)) << FBA_FRAME_SHIFT;
      a[FBA_FRAME_SHIFT-1:0] = FBA_FRAME_SHIFT'($urandom);
      l = ADDR_W'($urandom_range(0, 64 * PAGE_BYTES));
      if (pick < 35)      send_item(KIND_ALLOC, ADDR_W'({$urandom, $urandom}),
                                    ADDR_W'({$urandom, $urandom}));
      else if (pick < 60) send_item(KIND_FREE, a, l);
      else if (pick < 76) send_item(KIND_RELEASE, a, l);
      else if (pick < 91) send_item(KIND_RESERVE, a, l);
      else if (pick < 93) send_item(KIND_MARK, a, l);
      else                send_item(KIND_W'($urandom), ADDR_W'({$urandom, $urandom}),
                                    ADDR_W'({$urandom, $urandom}));
    end
    no_gaps = 1'b0;
  endtask

  // Hold the receiver off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    send_item(KIND_RELEASE, '0, 48'h0000_0004_0000);
    repeat (10) send_item(KIND_ALLOC, '0, '0);
    no_gaps = 1'b0;
  endtask

  task automatic test_total(logic [TOTAL_W-1:0] value, int count);
    write_total(value);
    send_item(KIND_RELEASE, '0, 48'h0000_0000_8000);
    send_item(KIND_ALLOC, '0, '0);
    random_items(count);
  endtask

  initial begin
    total_reg = FBA_MAX_FRAMES;
    mark_every_frame();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    random_items(340);
    test_total(17'd300, 200);
    test_total(17'd64, 150);
    test_total(17'h1FFFF, 200);
    test_total(17'd0, 60);
    test_total(17'd1, 100);
    test_total(17'd65, 150);
    test_total(17'd1000, 200);
    test_total(17'd65536, 150);

    drain();
    repeat (30) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("frame_bitmap_allocator_unit: match");
    end else begin
      $display("frame_bitmap_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
